FILE: hw/rtl/csma_pkg.sv
// Shared types, codes and helpers for the CSMA/CA sender backoff block.
`timescale 1ns / 1ps
`default_nettype none

package csma_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [11:0] CW_CAP     = 12'd1024;
  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  // Station state codes as reported on the result stream
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_SENSE     = 3'd2;
  localparam logic [2:0] ST_BACKOFF   = 3'd3;
  localparam logic [2:0] ST_REQUEST   = 3'd4;
  localparam logic [2:0] ST_AWAIT_CLR = 3'd5;
  localparam logic [2:0] ST_TRANSMIT  = 3'd6;
  localparam logic [2:0] ST_AWAIT_ACK = 3'd7;

  // Transmitted fragment kinds
  localparam logic TXK_RTS  = 1'b0;
  localparam logic TXK_DATA = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ARRIVAL = 2'd1,
    CMD_FRAME   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FT_DATA = 2'd0,
    FT_ACK  = 2'd1,
    FT_RTS  = 2'd2,
    FT_CTS  = 2'd3
  } frame_type_t;

  localparam logic [7:0] REG_STATION_ID    = 8'd0;
  localparam logic [7:0] REG_VCS_ENABLE    = 8'd1;
  localparam logic [7:0] REG_DIFS_LENGTH   = 8'd2;
  localparam logic [7:0] REG_ACK_TIMEOUT   = 8'd3;
  localparam logic [7:0] REG_DATA_TICKS    = 8'd4;
  localparam logic [7:0] REG_NAV_AFTER_RTS = 8'd5;
  localparam logic [7:0] REG_NAV_AFTER_CTS = 8'd6;
  localparam logic [7:0] REG_CW_MIN        = 8'd7;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_dest;
  } q_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       last;       // exactly one entry left
    logic [7:0] head_dest;  // zero when empty
  } q_stat_t;

  // One step of the 16-bit Galois LFSR
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) s = s ^ LFSR_TAPS;
    return s;
  endfunction

  // Double the window, capped
  function automatic logic [10:0] widen(input logic [10:0] w);
    logic [11:0] cw;
    cw = {w, 1'b0};
    return (cw > CW_CAP) ? CW_CAP[10:0] : cw[10:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/csma_dest_queue.sv
// Destination FIFO: storage, head pointer and fill count.
`timescale 1ns / 1ps
`default_nettype none

module csma_dest_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire csma_pkg::q_ctrl_t ctrl,
  output csma_pkg::q_stat_t      stat
);
  import csma_pkg::*;

  localparam int SW = QW + 1;

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [QW-1:0] head_r;
  logic [FW-1:0] fill_r;
  logic [SW-1:0] tail_sum;
  logic [QW-1:0] tail;

  always_comb begin
    tail_sum = SW'(head_r) + SW'(fill_r);
    if (tail_sum >= SW'(QUEUE_DEPTH)) tail_sum = tail_sum - SW'(QUEUE_DEPTH);
    tail = tail_sum[QW-1:0];
  end

  assign stat.empty     = (fill_r == '0);
  assign stat.full      = (fill_r == FW'(QUEUE_DEPTH));
  assign stat.last      = (fill_r == FW'(1));
  assign stat.head_dest = stat.empty ? 8'd0 : mem[head_r];

  always_ff @(posedge clk) begin
    if (ctrl.push) mem[tail] <= ctrl.push_dest;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else if (ctrl.push) begin
      fill_r <= fill_r + FW'(1);
    end else if (ctrl.pop) begin
      fill_r <= fill_r - FW'(1);
      head_r <= (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + QW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/csma_ca_sender_backoff_core.sv
// Top level: CSMA/CA sender state machine with backoff and registered result stage.
// Result: the result of an item is registered and is on out_* in the cycle after its transaction.
// Throughput: one item per cycle; all state updates happen in the accepting cycle
//   and the single output register frees in_tready whenever it drains or is empty.
// Reset (rst_n low, synchronous): idle state, window 4, LFSR seed 0xACE1, empty queue,
//   registers at their defaults; queue storage itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module csma_ca_sender_backoff_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // cfg
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // in
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // medium_busy[0], frame_dest[8:1], frame_ours[9], zero
  input  wire logic [3:0]  in_tuser,  // command[1:0], frame_type[3:2]
  // out
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata, // tx_valid[0], tx_dest[8:1], station_state[11:9],
                                      // window_size[22:12], packets_sent[54:23],
                                      // arrival_dropped[55]
  output logic [0:0]       out_tuser  // tx_kind[0]
);
  import csma_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE      = ST_IDLE,
    PH_READY     = ST_READY,
    PH_SENSE     = ST_SENSE,
    PH_BACKOFF   = ST_BACKOFF,
    PH_REQUEST   = ST_REQUEST,
    PH_AWAIT_CLR = ST_AWAIT_CLR,
    PH_TRANSMIT  = ST_TRANSMIT,
    PH_AWAIT_ACK = ST_AWAIT_ACK
  } phase_t;

  // configuration
  logic [7:0]  station_id_r;
  logic        vcs_enable_r;
  logic [7:0]  difs_length_r;
  logic [10:0] ack_timeout_r;
  logic [11:0] data_ticks_r;
  logic [11:0] nav_after_rts_r;
  logic [11:0] nav_after_cts_r;
  logic [10:0] cw_min_r;

  // station state
  phase_t      phase_r,       phase_nxt;
  logic [9:0]  backoff_r,     backoff_nxt;
  logic [7:0]  sense_r,       sense_nxt;
  logic [11:0] nav_r,         nav_nxt;
  logic [10:0] window_r,      window_nxt;
  logic [2:0]  clr_r,         clr_nxt;
  logic [11:0] ackw_r,        ackw_nxt;
  logic [1:0]  acks_r,        acks_nxt;
  logic [11:0] sent_ticks_r,  sent_ticks_nxt;
  logic [15:0] lfsr_r,        lfsr_nxt;
  logic [31:0] sent_total_r,  sent_total_nxt;

  // result stage
  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic [0:0]  out_user_r;

  q_ctrl_t     q_ctrl;
  q_stat_t     q_stat;

  logic        in_accept;
  cmd_t        cmd;
  frame_type_t ftype;
  logic        busy, ours;
  logic [7:0]  dest;

  logic        tx_valid, tx_kind, dropped;
  logic [7:0]  tx_dest;
  logic [2:0]  clr_was;
  logic [11:0] ackw_was;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign cmd   = cmd_t'(in_tuser[1:0]);
  assign ftype = frame_type_t'(in_tuser[3:2]);
  assign busy  = in_tdata[0];
  assign dest  = in_tdata[8:1];
  assign ours  = in_tdata[9];

  csma_dest_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (q_ctrl),
    .stat (q_stat)
  );

  always_comb begin
    phase_nxt      = phase_r;
    backoff_nxt    = backoff_r;
    sense_nxt      = sense_r;
    nav_nxt        = nav_r;
    window_nxt     = window_r;
    clr_nxt        = clr_r;
    ackw_nxt       = ackw_r;
    acks_nxt       = acks_r;
    sent_ticks_nxt = sent_ticks_r;
    lfsr_nxt       = lfsr_r;
    sent_total_nxt = sent_total_r;
    q_ctrl         = '0;
    q_ctrl.push_dest = dest;
    tx_valid       = 1'b0;
    tx_kind        = TXK_RTS;
    tx_dest        = 8'd0;
    dropped        = 1'b0;
    clr_was        = clr_r;
    ackw_was       = ackw_r;

    if (in_accept) begin
      case (cmd)
        CMD_TICK: begin
          // transmit half
          case (phase_nxt)
            PH_READY: begin
              lfsr_nxt    = lfsr_step(lfsr_nxt);
              backoff_nxt = lfsr_nxt[9:0] & (window_nxt[9:0] - 10'd1);
              sense_nxt   = difs_length_r;
              phase_nxt   = PH_SENSE;
            end
            PH_REQUEST: begin
              tx_valid = 1'b1;
              tx_kind  = TXK_RTS;
              tx_dest  = q_stat.head_dest;
              clr_nxt  = clr_nxt + 3'd1;
              if (clr_nxt > 3'd1) begin
                clr_nxt   = 3'd0;
                phase_nxt = PH_AWAIT_CLR;
              end
            end
            PH_TRANSMIT: begin
              tx_valid       = 1'b1;
              tx_kind        = TXK_DATA;
              tx_dest        = q_stat.head_dest;
              sent_ticks_nxt = sent_ticks_nxt + 12'd1;
              if (sent_ticks_nxt == data_ticks_r) begin
                phase_nxt      = PH_AWAIT_ACK;
                ackw_nxt       = 12'd0;
                sent_ticks_nxt = 12'd0;
              end
            end
            default: ;
          endcase

          // sensing half
          case (phase_nxt)
            PH_IDLE: begin
              if (!q_stat.empty) phase_nxt = PH_READY;
            end
            PH_SENSE: begin
              if (busy) begin
                sense_nxt = difs_length_r;
              end else begin
                sense_nxt = sense_nxt - 8'd1;
                if (sense_nxt == 8'd0) begin
                  clr_nxt = 3'd0;
                  if (backoff_nxt != 10'd0) phase_nxt = PH_BACKOFF;
                  else phase_nxt = vcs_enable_r ? PH_REQUEST : PH_TRANSMIT;
                end
              end
            end
            PH_BACKOFF: begin
              if (nav_r == 12'd0) begin
                if (busy) begin
                  sense_nxt = difs_length_r;
                  phase_nxt = PH_SENSE;
                end else begin
                  backoff_nxt = backoff_nxt - 10'd1;
                  if (backoff_nxt == 10'd0) begin
                    clr_nxt   = 3'd0;
                    phase_nxt = vcs_enable_r ? PH_REQUEST : PH_TRANSMIT;
                  end
                end
              end
            end
            PH_AWAIT_CLR: begin
              clr_was = clr_nxt;
              clr_nxt = clr_nxt + 3'd1;
              if (clr_was > 3'd4) begin
                window_nxt  = widen(window_nxt);
                lfsr_nxt    = lfsr_step(lfsr_nxt);
                backoff_nxt = lfsr_nxt[9:0] & (window_nxt[9:0] - 10'd1);
                sense_nxt   = difs_length_r;
                phase_nxt   = PH_SENSE;
              end
            end
            PH_AWAIT_ACK: begin
              if (acks_nxt == 2'd2) begin
                sent_total_nxt = sent_total_nxt + 32'd1;
                window_nxt     = cw_min_r;
                lfsr_nxt       = lfsr_step(lfsr_nxt);
                backoff_nxt    = lfsr_nxt[9:0] & (window_nxt[9:0] - 10'd1);
                sense_nxt      = difs_length_r;
                q_ctrl.pop     = !q_stat.empty;
                phase_nxt      = (q_stat.empty || q_stat.last) ? PH_IDLE : PH_READY;
                acks_nxt       = 2'd0;
              end else begin
                ackw_was = ackw_nxt;
                ackw_nxt = ackw_nxt + 12'd1;
                if (ackw_was > ({1'b0, ack_timeout_r} + 12'd1)) begin
                  window_nxt  = widen(window_nxt);
                  lfsr_nxt    = lfsr_step(lfsr_nxt);
                  backoff_nxt = lfsr_nxt[9:0] & (window_nxt[9:0] - 10'd1);
                  sense_nxt   = difs_length_r;
                  phase_nxt   = PH_SENSE;
                  acks_nxt    = 2'd0;
                end
              end
            end
            default: ;
          endcase

          if (nav_r != 12'd0) nav_nxt = nav_r - 12'd1;
        end

        CMD_ARRIVAL: begin
          if (q_stat.full) dropped = 1'b1;
          else q_ctrl.push = 1'b1;
        end

        CMD_FRAME: begin
          if (phase_r == PH_AWAIT_ACK && ftype == FT_ACK && ours) begin
            if (acks_r != 2'd3) acks_nxt = acks_r + 2'd1;
          end else if (dest != station_id_r && phase_r != PH_REQUEST &&
                       phase_r != PH_AWAIT_CLR) begin
            if (ftype == FT_RTS) nav_nxt = nav_after_rts_r;
            else if (ftype == FT_CTS) nav_nxt = nav_after_cts_r;
          end else if (dest == station_id_r && ftype == FT_CTS) begin
            // clearance only honored on the matching wait count
            if (clr_r == 3'd3) phase_nxt = PH_TRANSMIT;
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_id_r    <= 8'd0;
      vcs_enable_r    <= 1'b0;
      difs_length_r   <= 8'd2;
      ack_timeout_r   <= 11'd10;
      data_ticks_r    <= 12'd100;
      nav_after_rts_r <= 12'd105;
      nav_after_cts_r <= 12'd103;
      cw_min_r        <= 11'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STATION_ID:    station_id_r    <= cfg_data[7:0];
        REG_VCS_ENABLE:    vcs_enable_r    <= cfg_data[0];
        REG_DIFS_LENGTH:   difs_length_r   <= cfg_data[7:0];
        REG_ACK_TIMEOUT:   ack_timeout_r   <= cfg_data[10:0];
        REG_DATA_TICKS:    data_ticks_r    <= cfg_data[11:0];
        REG_NAV_AFTER_RTS: nav_after_rts_r <= cfg_data[11:0];
        REG_NAV_AFTER_CTS: nav_after_cts_r <= cfg_data[11:0];
        REG_CW_MIN:        cw_min_r        <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      backoff_r    <= 10'd0;
      sense_r      <= 8'd0;
      nav_r        <= 12'd0;
      window_r     <= 11'd4;
      clr_r        <= 3'd0;
      ackw_r       <= 12'd0;
      acks_r       <= 2'd0;
      sent_ticks_r <= 12'd0;
      lfsr_r       <= LFSR_SEED;
      sent_total_r <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      backoff_r    <= backoff_nxt;
      sense_r      <= sense_nxt;
      nav_r        <= nav_nxt;
      window_r     <= window_nxt;
      clr_r        <= clr_nxt;
      ackw_r       <= ackw_nxt;
      acks_r       <= acks_nxt;
      sent_ticks_r <= sent_ticks_nxt;
      lfsr_r       <= lfsr_nxt;
      sent_total_r <= sent_total_nxt;
      if (in_tready) out_valid_r <= in_accept;
    end
  end

  // result payload reflects the state after the item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {dropped, sent_total_nxt, window_nxt, phase_nxt, tx_dest, tx_valid};
      out_user_r <= tx_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

FILE: hw/rtl/csma_checker.sv
// Port-level checker for the CSMA/CA sender core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csma_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [0:0]  out_tuser
);
  import csma_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no fragment means no kind or destination
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tuser[0] == TXK_RTS && out_tdata[8:1] == 8'd0)
    else $error("tx fields set without a fragment");

  // a transmitting tick never drops an arrival
  a_tx_not_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[55])
    else $error("fragment and drop in one result");

  // fragment kind agrees with the reported state
  a_kind_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      (out_tuser[0] == TXK_DATA &&
        (out_tdata[11:9] == ST_TRANSMIT || out_tdata[11:9] == ST_AWAIT_ACK)) ||
      (out_tuser[0] == TXK_RTS &&
        (out_tdata[11:9] == ST_REQUEST || out_tdata[11:9] == ST_AWAIT_CLR)))
    else $error("fragment kind does not match state");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind csma_ca_sender_backoff_core csma_checker u_csma_checker (.*);

`default_nettype wire

FILE: tb/csma_ca_sender_backoff_core_test.sv
// Testbench for the CSMA/CA sender backoff core: directed and random items checked per result.
`timescale 1ns / 1ps

module csma_ca_sender_backoff_core_test;
  import csma_pkg::*;

  localparam logic [15:0] PRNG_SEED    = 16'hACE1;
  localparam logic [15:0] PRNG_TAPS    = 16'hB400;
  localparam logic [11:0] WINDOW_CAP   = 12'd1024;
  localparam int          QSLOTS       = 16;
  localparam int          DRAIN_CYCLES = 3;
  localparam int          CYCLE_LIMIT  = 1_500_000;

  typedef struct packed {
    logic        tx_valid;
    logic        tx_kind;
    logic [7:0]  tx_dest;
    logic [2:0]  state;
    logic [10:0] window;
    logic [31:0] sent;
    logic        dropped;
  } station_status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        busy;
    logic [7:0]  dest;
    frame_type_t ftype;
    logic        ours;
  } air_item_t;

  // Tracks the sender state per accepted item and holds the status each item should report.
  class backoff_scoreboard;
    logic [7:0]  my_id;
    logic        rts_cts_on;
    logic [7:0]  difs_len;
    logic [10:0] ack_limit;
    logic [11:0] pkt_ticks;
    logic [11:0] nav_rts_load;
    logic [11:0] nav_cts_load;
    logic [10:0] cw_floor;

    logic [2:0]  st;
    logic [9:0]  bo_left;
    logic [7:0]  difs_left;
    logic [11:0] nav_left;
    logic [10:0] cw;
    logic [2:0]  clr_cnt;
    logic [11:0] ack_wait;
    logic [1:0]  ack_hits;
    logic [11:0] tx_ticks;
    logic [7:0]  q_mem [QSLOTS];
    logic [4:0]  q_fill;
    logic [3:0]  q_head;
    logic [15:0] lfsr_q;
    logic [31:0] acked_pkts;

    int mismatches;
    station_status_t expected_q[$];

    function new();
      my_id = 8'd0; rts_cts_on = 1'b0; difs_len = 8'd2; ack_limit = 11'd10;
      pkt_ticks = 12'd100; nav_rts_load = 12'd105; nav_cts_load = 12'd103; cw_floor = 11'd4;
      st = ST_IDLE; bo_left = '0; difs_left = '0; nav_left = '0; cw = cw_floor;
      clr_cnt = '0; ack_wait = '0; ack_hits = '0; tx_ticks = '0;
      q_fill = '0; q_head = '0; lfsr_q = PRNG_SEED; acked_pkts = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [7:0] idx, logic [11:0] v);
      case (idx)
        REG_STATION_ID:    my_id = v[7:0];
        REG_VCS_ENABLE:    rts_cts_on = v[0];
        REG_DIFS_LENGTH:   difs_len = v[7:0];
        REG_ACK_TIMEOUT:   ack_limit = v[10:0];
        REG_DATA_TICKS:    pkt_ticks = v;
        REG_NAV_AFTER_RTS: nav_rts_load = v;
        REG_NAV_AFTER_CTS: nav_cts_load = v;
        REG_CW_MIN:        cw_floor = v[10:0];
        default: ;
      endcase
    endfunction

    // Galois step, then mask by window-1 (a zero window gives the full 10-bit mask)
    function logic [9:0] draw_slots();
      logic [10:0] mask;
      lfsr_q = lfsr_q[0] ? ({1'b0, lfsr_q[15:1]} ^ PRNG_TAPS) : {1'b0, lfsr_q[15:1]};
      mask = cw - 11'd1;
      return lfsr_q[9:0] & mask[9:0];
    endfunction

    function void double_window();
      logic [11:0] d;
      d = {cw, 1'b0};
      cw = (d > WINDOW_CAP) ? WINDOW_CAP[10:0] : d[10:0];
    endfunction

    function void retry_contention();
      double_window();
      bo_left = draw_slots();
      difs_left = difs_len;
      st = ST_SENSE;
    endfunction

    function void clear_or_send();
      clr_cnt = '0;
      st = rts_cts_on ? ST_REQUEST : ST_TRANSMIT;
    endfunction

    function logic [7:0] head_dest();
      return (q_fill == 0) ? 8'h00 : q_mem[q_head];
    endfunction

    function void note_item(air_item_t it);
      station_status_t r;
      logic [11:0] was_wait;
      logic [2:0]  was_clr;
      logic [3:0]  slot;
      r = '0;
      case (it.cmd)
        CMD_TICK: begin
          // transmit half
          case (st)
            ST_READY: begin
              bo_left = draw_slots();
              difs_left = difs_len;
              st = ST_SENSE;
            end
            ST_REQUEST: begin
              r.tx_valid = 1'b1; r.tx_kind = TXK_RTS; r.tx_dest = head_dest();
              clr_cnt = clr_cnt + 3'd1;
              if (clr_cnt > 3'd1) begin
                clr_cnt = '0;
                st = ST_AWAIT_CLR;
              end
            end
            ST_TRANSMIT: begin
              r.tx_valid = 1'b1; r.tx_kind = TXK_DATA; r.tx_dest = head_dest();
              tx_ticks = tx_ticks + 12'd1;
              if (tx_ticks == pkt_ticks) begin
                st = ST_AWAIT_ACK;
                ack_wait = '0;
                tx_ticks = '0;
              end
            end
            default: ;
          endcase
          // sensing half
          case (st)
            ST_IDLE: if (q_fill != 0) st = ST_READY;
            ST_SENSE: begin
              if (it.busy) begin
                difs_left = difs_len;
              end else begin
                difs_left = difs_left - 8'd1;
                if (difs_left == 0) begin
                  clr_cnt = '0;
                  if (bo_left != 0) st = ST_BACKOFF;
                  else clear_or_send();
                end
              end
            end
            ST_BACKOFF: begin
              if (nav_left == 0) begin
                if (it.busy) begin
                  difs_left = difs_len;
                  st = ST_SENSE;
                end else begin
                  bo_left = bo_left - 10'd1;
                  if (bo_left == 0) clear_or_send();
                end
              end
            end
            ST_AWAIT_CLR: begin
              was_clr = clr_cnt;
              clr_cnt = clr_cnt + 3'd1;
              if (was_clr > 3'd4) retry_contention();
            end
            ST_AWAIT_ACK: begin
              if (ack_hits == 2'd2) begin
                acked_pkts = acked_pkts + 32'd1;
                cw = cw_floor;
                bo_left = draw_slots();
                difs_left = difs_len;
                if (q_fill != 0) begin
                  q_head = q_head + 4'd1;
                  q_fill = q_fill - 5'd1;
                end
                st = (q_fill == 0) ? ST_IDLE : ST_READY;
                ack_hits = '0;
              end else begin
                // counter runs one ahead of the wait count
                was_wait = ack_wait;
                ack_wait = ack_wait + 12'd1;
                if (int'(was_wait) > int'(ack_limit) + 1) begin
                  retry_contention();
                  ack_hits = '0;
                end
              end
            end
            default: ;
          endcase
          if (nav_left != 0) nav_left = nav_left - 12'd1;
        end
        CMD_ARRIVAL: begin
          if (q_fill >= QSLOTS) begin
            r.dropped = 1'b1;
          end else begin
            slot = q_head + q_fill[3:0];
            q_mem[slot] = it.dest;
            q_fill = q_fill + 5'd1;
          end
        end
        CMD_FRAME: begin
          if (st == ST_AWAIT_ACK && it.ftype == FT_ACK && it.ours) begin
            if (ack_hits < 2'd3) ack_hits = ack_hits + 2'd1;
          end else if (it.dest != my_id && st != ST_REQUEST && st != ST_AWAIT_CLR) begin
            if (it.ftype == FT_RTS) nav_left = nav_rts_load;
            else if (it.ftype == FT_CTS) nav_left = nav_cts_load;
          end else if (it.dest == my_id && it.ftype == FT_CTS) begin
            if (clr_cnt == 3'd3) st = ST_TRANSMIT;
          end
        end
        default: ;
      endcase
      r.state = st;
      r.window = cw;
      r.sent = acked_pkts;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 50)
        $display("%0t: %s mismatch, got %0h want %0h", $time, field, got, want);
    endtask

    task check_result(logic [55:0] d, logic [0:0] u);
      station_status_t e;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", d[31:0], 32'd0);
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (d[0] !== e.tx_valid) report("tx_valid", 32'(d[0]), 32'(e.tx_valid));
      if (u[0] !== e.tx_kind) report("tx_kind", 32'(u[0]), 32'(e.tx_kind));
      if (d[8:1] !== e.tx_dest) report("tx_dest", 32'(d[8:1]), 32'(e.tx_dest));
      if (d[11:9] !== e.state) report("station_state", 32'(d[11:9]), 32'(e.state));
      if (d[22:12] !== e.window) report("window_size", 32'(d[22:12]), 32'(e.window));
      if (d[54:23] !== e.sent) report("packets_sent", d[54:23], e.sent);
      if (d[55] !== e.dropped) report("arrival_dropped", 32'(d[55]), 32'(e.dropped));
    endtask

    task check_leftover();
      if (expected_q.size() != 0)
        report("missing transactions", 32'(expected_q.size()), 32'd0);
    endtask
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [7:0]  cfg_index  = '0;
  logic [11:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  wire         cfg_ready;
  wire         in_tready;
  wire         out_tvalid;
  wire  [55:0] out_tdata;
  wire  [0:0]  out_tuser;

  backoff_scoreboard sb = new();

  int arrival_pct;
  int busy_pct;
  int noise_pct;
  bit calm;

  csma_ca_sender_backoff_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("csma_ca_sender_backoff_core_test NOT OK");
    $finish;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 72) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(24, 8);
  endfunction

  function automatic air_item_t mk(cmd_t c, logic b, logic [7:0] d, frame_type_t f, logic o);
    air_item_t it;
    it.cmd = c; it.busy = b; it.dest = d; it.ftype = f; it.ours = o;
    return it;
  endfunction

  // Mostly ticks, steered by the tracked state so handshakes with the air get completed.
  function automatic air_item_t pick_item();
    air_item_t it;
    int r;
    it.cmd   = CMD_TICK;
    it.busy  = ($urandom_range(99) < busy_pct);
    it.dest  = 8'($urandom_range(255));
    it.ftype = frame_type_t'($urandom_range(3));
    it.ours  = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < noise_pct) begin
      it.cmd  = cmd_t'($urandom_range(3));
      it.busy = 1'($urandom_range(1));
      return it;
    end
    if (r < noise_pct + arrival_pct) begin
      it.cmd = CMD_ARRIVAL;
      return it;
    end
    case (sb.st)
      ST_AWAIT_ACK: begin
        if ($urandom_range(99) < 35) begin
          it.cmd = CMD_FRAME;
          it.ftype = FT_ACK;
          it.ours = ($urandom_range(9) != 0);
        end
      end
      ST_AWAIT_CLR: begin
        if (sb.clr_cnt == 3'd3 && $urandom_range(99) < 70) begin
          it.cmd = CMD_FRAME;
          it.ftype = FT_CTS;
          it.dest = sb.my_id;
        end
      end
      ST_IDLE, ST_SENSE, ST_BACKOFF: begin
        if ($urandom_range(99) < 4) begin
          it.cmd = CMD_FRAME;
          it.ftype = $urandom_range(1) ? FT_RTS : FT_CTS;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic send_item(input air_item_t it);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, it.ours, it.dest, it.busy};
    in_tuser  <= {it.ftype, it.cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] id, input logic vcs, input logic [7:0] difs,
                               input logic [10:0] ack_to, input logic [11:0] dticks,
                               input logic [11:0] nav_r, input logic [11:0] nav_c,
                               input logic [10:0] cw_lo);
    logic [7:0]  regs [8];
    logic [11:0] vals [8];
    regs = '{REG_STATION_ID, REG_VCS_ENABLE, REG_DIFS_LENGTH, REG_ACK_TIMEOUT,
             REG_DATA_TICKS, REG_NAV_AFTER_RTS, REG_NAV_AFTER_CTS, REG_CW_MIN};
    vals = '{12'(id), 12'(vcs), 12'(difs), 12'(ack_to), dticks, nav_r, nav_c, 12'(cw_lo)};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int arr, input int bsy, input int noise,
                           input int pause_at);
    arrival_pct = arr;
    busy_pct    = bsy;
    noise_pct   = noise;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) calm = ($urandom_range(3) == 0);
      send_item(pick_item());
      if (i == n - 1 || i == pause_at) wait_drained();
      else idle_sender(idle_len());
    end
  endtask

  // Result side: accepts and checks transactions, stalls at random, one long hold early on.
  initial begin : result_side
    int stall_left;
    int seen;
    bit held;
    stall_left = 0;
    seen = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tuser);
        seen++;
      end
      if (!held && seen == 60) begin
        held = 1'b1;
        stall_left = 150;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    calm = 1'b1;
    arrival_pct = 0;
    busy_pct = 0;
    noise_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, station 0
    send_item(mk(CMD_NONE, 1'b1, 8'hFF, FT_CTS, 1'b1));
    send_item(mk(CMD_FRAME, 1'b0, 8'hFF, FT_RTS, 1'b0));    // overheard RTS loads NAV
    send_item(mk(CMD_FRAME, 1'b0, 8'h01, FT_CTS, 1'b0));    // overheard CTS reloads NAV
    send_item(mk(CMD_FRAME, 1'b0, 8'h00, FT_DATA, 1'b1));
    send_item(mk(CMD_FRAME, 1'b1, 8'h80, FT_ACK, 1'b1));    // ACK outside ack wait
    send_item(mk(CMD_ARRIVAL, 1'b0, 8'hFF, FT_DATA, 1'b0));
    send_item(mk(CMD_ARRIVAL, 1'b1, 8'h00, FT_ACK, 1'b1));
    for (int k = 0; k < 14; k++)
      send_item(mk(CMD_ARRIVAL, k[0], 8'(k * 17 + 3), frame_type_t'(k % 4), k[1]));
    send_item(mk(CMD_ARRIVAL, 1'b0, 8'hA5, FT_DATA, 1'b0)); // queue full: dropped
    send_item(mk(CMD_TICK, 1'b1, 8'h00, FT_DATA, 1'b0));
    send_item(mk(CMD_TICK, 1'b0, 8'h00, FT_DATA, 1'b0));
    send_item(mk(CMD_FRAME, 1'b0, 8'h00, FT_CTS, 1'b0));    // CTS to us without clearance
    wait_drained();

    load_settings(8'h3C, 1'b0, 8'd1, 11'd3, 12'd2, 12'd0, 12'd20, 11'd1);
    run_phase(150, 6, 10, 8, -1);
    load_settings(8'hC3, 1'b1, 8'd2, 11'd0, 12'd1, 12'd7, 12'd3, 11'd4);
    run_phase(150, 5, 10, 8, 100);
    load_settings(8'hFF, 1'b1, 8'd3, 11'd2047, 12'd5, 12'd4095, 12'd0, 11'd1024);
    run_phase(130, 4, 8, 8, -1);
    load_settings(8'h00, 1'b0, 8'd255, 11'd5, 12'd4095, 12'd1, 12'd4095, 11'd2);
    run_phase(80, 10, 1, 8, -1);
    // zero minimum window
    load_settings(8'h81, 1'b1, 8'd1, 11'd1, 12'd2, 12'd50, 12'd60, 11'd0);
    run_phase(150, 5, 10, 8, -1);
    // zero DIFS and zero data length
    load_settings(8'h7E, 1'b0, 8'd0, 11'd4, 12'd0, 12'd9, 12'd9, 11'd2);
    run_phase(140, 1, 0, 0, -1);
    load_settings(8'h3C, 1'b1, 8'd2, 11'd10, 12'd3, 12'd105, 12'd103, 11'd4);
    run_phase(100, 6, 10, 8, -1);

    sb.check_leftover();
    if (sb.mismatches == 0) $display("csma_ca_sender_backoff_core_test OK");
    else $display("csma_ca_sender_backoff_core_test NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/csma_pkg.sv
hw/rtl/csma_dest_queue.sv
hw/rtl/csma_ca_sender_backoff_core.sv
hw/rtl/csma_checker.sv
tb/csma_ca_sender_backoff_core_test.sv
